// ===== rtl/mctpg_pkg.sv =====
package mctpg_pkg;

    localparam int unsigned PIN_BITS = 4;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_PLAY  = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    typedef struct packed {
        logic [PIN_BITS-1:0] pin_levels;
        logic [PIN_BITS-1:0] active_mask;
        logic                queried_playing;
        logic                bad_channel;
    } result_t;

endpackage

// ===== rtl/multi_channel_tone_pulse_generator.sv =====
// Channel | Direction | Handshake             | Payload
// s_      | in        | s_valid / s_ready     | func, channel, period_ms, on_ms, pulse_count
// m_      | out       | m_valid / m_ready     | pin_levels, active_mask, queried_playing,
//         |           |                       | bad_channel
// cfg_    | in        | cfg_valid / cfg_ready | data (default_levels)
//
// One item per cycle while s_ready is high. Every channel is updated in the cycle the item is taken
// and its result is registered into the output register, or into the skid register while the output register is full.
// A two-entry output stage (output register plus skid register) lets the
// input take an item while one result waits; s_ready falls only when both are full.
// Reset (aresetn low, synchronous) clears all channel state, the default
// levels and both output entries. cfg_ready is always high.
module multi_channel_tone_pulse_generator
    import mctpg_pkg::*;
#(
    parameter int unsigned CHANNELS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PIN_BITS-1:0] cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [7:0]          s_channel,
    input  logic [15:0]         s_period_ms,
    input  logic [15:0]         s_on_ms,
    input  logic [7:0]          s_pulse_count,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [PIN_BITS-1:0] m_pin_levels,
    output logic [PIN_BITS-1:0] m_active_mask,
    output logic                m_queried_playing,
    output logic                m_bad_channel
);

    logic [PIN_BITS-1:0] default_levels_reg;

    logic [15:0] on_len_reg   [CHANNELS];
    logic [15:0] on_len_next  [CHANNELS];
    logic [15:0] off_len_reg  [CHANNELS];
    logic [15:0] off_len_next [CHANNELS];
    logic [7:0]  pulses_reg   [CHANNELS];
    logic [7:0]  pulses_next  [CHANNELS];
    logic [15:0] wait_reg     [CHANNELS];
    logic [15:0] wait_next    [CHANNELS];
    logic [CHANNELS-1:0] phase_reg;
    logic [CHANNELS-1:0] phase_next;
    logic [CHANNELS-1:0] active_reg;
    logic [CHANNELS-1:0] active_next;
    logic [CHANNELS-1:0] pin_reg;
    logic [CHANNELS-1:0] pin_next;
    logic [CHANNELS-1:0] queried_vec;

    result_t out_reg;
    result_t skid_reg;
    result_t result;
    logic    out_valid_reg;
    logic    skid_valid_reg;

    logic    accept;
    logic    pop;
    logic    is_tick;
    logic    bad;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~skid_valid_reg;
    assign accept    = s_valid & s_ready;
    assign pop       = out_valid_reg & m_ready;

    assign is_tick = (func_t'(s_func) == FUNC_TICK);
    assign bad     = ~is_tick && (s_channel >= 8'(CHANNELS));

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        logic sel;
        assign sel = ~is_tick && (s_channel == 8'(c));

        always_comb begin
            logic [15:0] dec;
            logic [15:0] len;
            dec = (wait_reg[c] != 16'd0) ? wait_reg[c] - 16'd1 : 16'd0;
            len = phase_reg[c] ? off_len_reg[c] : on_len_reg[c];

            on_len_next[c]  = on_len_reg[c];
            off_len_next[c] = off_len_reg[c];
            pulses_next[c]  = pulses_reg[c];
            wait_next[c]    = wait_reg[c];
            phase_next[c]   = phase_reg[c];
            active_next[c]  = active_reg[c];
            pin_next[c]     = pin_reg[c];
            queried_vec[c]  = 1'b0;

            if (is_tick) begin
                if (active_reg[c]) begin
                    wait_next[c] = dec;
                    if (dec == 16'd0) begin
                        // expiry: an on phase with no pulses left ends the train
                        if (!phase_reg[c] && pulses_reg[c] == 8'd0) begin
                            active_next[c] = 1'b0;
                            pin_next[c]    = default_levels_reg[c];
                        end else begin
                            if (!phase_reg[c]) begin
                                pulses_next[c] = pulses_reg[c] - 8'd1;
                            end
                            wait_next[c]  = (len == 16'd0) ? 16'd1 : len;
                            phase_next[c] = ~phase_reg[c];
                            if (on_len_reg[c] != 16'd0) begin
                                pin_next[c] = ~pin_reg[c];
                            end
                        end
                    end
                end
            end else if (sel) begin
                case (func_t'(s_func))
                    FUNC_PLAY: begin
                        on_len_next[c]  = s_on_ms;
                        off_len_next[c] = s_period_ms - s_on_ms;
                        phase_next[c]   = 1'b0;
                        pulses_next[c]  = s_pulse_count;
                        active_next[c]  = 1'b1;
                        wait_next[c]    = 16'd0;
                    end
                    FUNC_STOP: begin
                        active_next[c] = 1'b0;
                        pin_next[c]    = default_levels_reg[c];
                    end
                    FUNC_QUERY: begin
                        queried_vec[c] = active_reg[c];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        result                            = '0;
        result.pin_levels[CHANNELS-1:0]   = pin_next;
        result.active_mask[CHANNELS-1:0]  = active_next;
        result.queried_playing            = |queried_vec;
        result.bad_channel                = bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_levels_reg <= '0;
        end else if (cfg_valid) begin
            default_levels_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                on_len_reg[c]  <= '0;
                off_len_reg[c] <= '0;
                pulses_reg[c]  <= '0;
                wait_reg[c]    <= '0;
            end
            phase_reg  <= '0;
            active_reg <= '0;
            pin_reg    <= '0;
        end else if (accept) begin
            for (int c = 0; c < CHANNELS; c++) begin
                on_len_reg[c]  <= on_len_next[c];
                off_len_reg[c] <= off_len_next[c];
                pulses_reg[c]  <= pulses_next[c];
                wait_reg[c]    <= wait_next[c];
            end
            phase_reg  <= phase_next;
            active_reg <= active_next;
            pin_reg    <= pin_next;
        end
    end

    // output register with skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_pin_levels      = out_reg.pin_levels;
    assign m_active_mask     = out_reg.active_mask;
    assign m_queried_playing = out_reg.queried_playing;
    assign m_bad_channel     = out_reg.bad_channel;

endmodule

// ===== rtl/mctpg_checker.sv =====
module mctpg_checker
    import mctpg_pkg::*;
#(
    parameter int unsigned CHANNELS = 4
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [PIN_BITS-1:0] m_pin_levels,
    input logic [PIN_BITS-1:0] m_active_mask,
    input logic                m_queried_playing,
    input logic                m_bad_channel
);

    localparam logic [PIN_BITS-1:0] USED = PIN_BITS'((5'd1 << CHANNELS) - 5'd1);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pin_levels)
            && $stable(m_active_mask) && $stable(m_queried_playing)
            && $stable(m_bad_channel))
        else $error("result changed while stalled");

    a_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_pin_levels | m_active_mask) & ~USED) == '0)
        else $error("bits above the channel count set");

    a_query_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_queried_playing |-> !m_bad_channel && (m_active_mask != '0))
        else $error("query result inconsistent with flags");

    // nothing comes out in the cycle after reset
    a_no_spurious: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown straight after reset");

    a_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result waiting");

endmodule

bind multi_channel_tone_pulse_generator mctpg_checker #(.CHANNELS(CHANNELS)) u_mctpg_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_pin_levels      (m_pin_levels),
    .m_active_mask     (m_active_mask),
    .m_queried_playing (m_queried_playing),
    .m_bad_channel     (m_bad_channel)
);
